/* hw/rtl/pci_pkg.sv */
// shared types, codes and constants of the palette colormap interpolator
`default_nettype none
package pci_pkg;

	localparam int DEF_PALETTE_DEPTH = 16;
	localparam int DEF_CHANNEL_BITS  = 16;

	localparam int CHAN_W     = 16;
	localparam int VALUE_W    = 17;
	localparam int FRAC_W     = 16;
	localparam int IDX_W      = 4;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	localparam logic [VALUE_W-1:0] ONE_Q16 = 17'h10000;
	localparam int ROUND_HALF = 32768;

	// commands
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// interpolation spaces
	localparam logic [1:0] MODE_RGB  = 2'd0;
	localparam logic [1:0] MODE_HSV  = 2'd1;
	localparam logic [1:0] MODE_CMYK = 2'd2;
	localparam logic [1:0] MODE_HSL  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd1;

	typedef struct packed {
		logic               command;
		logic [IDX_W-1:0]   entry_index;
		logic [VALUE_W-1:0] value;
		logic               hue_undefined;
		logic [CHAN_W-1:0]  chan_0;
		logic [CHAN_W-1:0]  chan_1;
		logic [CHAN_W-1:0]  chan_2;
		logic [CHAN_W-1:0]  chan_3;
		logic [CHAN_W-1:0]  chan_4;
	} req_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_chan_0;
		logic [CHAN_W-1:0] out_chan_1;
		logic [CHAN_W-1:0] out_chan_2;
		logic [CHAN_W-1:0] out_chan_3;
		logic [CHAN_W-1:0] out_chan_4;
	} rsp_word_t;

endpackage
`default_nettype wire

/* hw/rtl/palette_colormap_interpolator_top.sv */
// top level of the palette colormap interpolator
`default_nettype none
// usage
//  - req channel (valid/ready) carries one word: a palette write or a lookup
//  - a write stores five channels and a hue-undefined flag, gives no result
//  - a lookup returns one colour word on the rsp channel (valid/ready)
//  - cfg port: cfg_we with cfg_index selects interp_mode (0) or entry_count (1);
//    the user must write only while the block is idle; the block does not enforce it
//  - throughput: one word per cycle while rsp does not stall; the limit is the palette memory, read at
//    both neighbour entries in the same cycle by its two read ports
//  - stages: s1 scales the position, s2 reads both entries, s3 holds the
//    channel products, then the output register
//  - a stall on rsp backs up stage by stage; empty stages still fill, so
//    req_ready stays high until every stage holds a word
//  - writes reach the memory in stage order, so lookups always see the
//    palette as written before them
//  - reset clears valid bits and the config registers; the palette holds no reset value
//    and entries must be written before they are looked up
module palette_colormap_interpolator_top #(
	parameter int PALETTE_DEPTH = pci_pkg::DEF_PALETTE_DEPTH,
	parameter int CHANNEL_BITS  = pci_pkg::DEF_CHANNEL_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pci_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pci_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire pci_pkg::req_word_t             req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output pci_pkg::rsp_word_t                  rsp
);
	import pci_pkg::*;

	localparam int CW     = $clog2(PALETTE_DEPTH+1);
	localparam int AW     = $clog2(PALETTE_DEPTH);
	localparam int CB     = CHANNEL_BITS;
	localparam int MAIN_W = 4 * CB;
	localparam int AUX_W  = CB + 1;
	localparam logic [CB-1:0] CHAN_MAX = {CB{1'b1}};

	// configuration
	logic [1:0]            mode_q;
	logic [CFG_DATA_W-1:0] count_q;
	logic [CW-1:0]         n_c;
	logic [CW-1:0]         nm1;
	logic                  is_cmyk;
	logic                  hue_fix_en;

	// stage valids and enables
	logic v1_s1, v2_s2, v3_s3;
	logic en1, en2, en3, en_out;

	// stage 1 payload
	logic          cmd_s1;
	logic [AW-1:0] widx_s1;
	logic          hue_u_s1;
	logic [CB-1:0] wch_s1 [5];

	// addressing
	logic [AW-1:0]     lo_addr, hi_addr;
	logic [FRAC_W-1:0] frac_s1, frac_s2;

	// memory ports
	logic              mem_we, mem_re;
	logic [MAIN_W-1:0] main_a, main_b;
	logic [AUX_W-1:0]  aux_a, aux_b;

	// blend operands and results
	logic [CB-1:0] ca [5];
	logic [CB-1:0] cb [5];
	logic [CB-1:0] res [5];
	logic [CB-1:0] fin [5];
	logic          ua, ub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RGB;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTERP_MODE: mode_q  <= cfg_data[1:0];
				REG_ENTRY_COUNT: count_q <= cfg_data;
			endcase
		end
	end

	// entries in use, saturated at the palette depth
	always_comb begin
		if (32'(count_q) > 32'(PALETTE_DEPTH)) begin
			n_c = CW'(PALETTE_DEPTH);
		end else begin
			n_c = CW'(count_q);
		end
	end

	assign nm1        = n_c - CW'(1);
	assign is_cmyk    = (mode_q == MODE_CMYK);
	// a single entry comes back as stored, undefined hue or not
	assign hue_fix_en = ((mode_q == MODE_HSV) || (mode_q == MODE_HSL)) && (n_c >= CW'(2));

	// stall chain: a stage moves when it is empty or the next one moves
	assign en_out    = !rsp_valid || rsp_ready;
	assign en3       = !v3_s3 || en_out;
	assign en2       = !v2_s2 || en3;
	assign en1       = !v1_s1 || en2;
	assign req_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (en1) begin
				v1_s1 <= req_valid;
			end
			// writes end in stage 1, only lookups travel on
			if (en2) begin
				v2_s2 <= v1_s1 && (cmd_s1 == CMD_LOOKUP);
			end
			if (en3) begin
				v3_s3 <= v2_s2;
			end
			if (en_out) begin
				rsp_valid <= v3_s3;
			end
		end
	end

	// stage 1 payload, channels trimmed to the stored width
	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1    <= req.command;
			widx_s1   <= AW'(req.entry_index);
			hue_u_s1  <= req.hue_undefined;
			wch_s1[0] <= req.chan_0[CB-1:0];
			wch_s1[1] <= req.chan_1[CB-1:0];
			wch_s1[2] <= req.chan_2[CB-1:0];
			wch_s1[3] <= req.chan_3[CB-1:0];
			wch_s1[4] <= req.chan_4[CB-1:0];
		end
	end

	pci_index #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_index (
		.clk    (clk),
		.en     (en1),
		.value  (req.value),
		.nm1    (nm1),
		.lo_addr(lo_addr),
		.hi_addr(hi_addr),
		.frac   (frac_s1)
	);

	// memory write and read both happen as stage 1 moves on, in word order
	assign mem_we = en2 && v1_s1 && (cmd_s1 == CMD_WRITE);
	assign mem_re = en2 && v1_s1 && (cmd_s1 == CMD_LOOKUP);

	pci_ram #(
		.WIDTH(MAIN_W),
		.DEPTH(PALETTE_DEPTH)
	) u_main (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (widx_s1),
		.wdata  ({wch_s1[3], wch_s1[2], wch_s1[1], wch_s1[0]}),
		.re     (mem_re),
		.raddr_a(lo_addr),
		.raddr_b(hi_addr),
		.rdata_a(main_a),
		.rdata_b(main_b)
	);

	pci_ram #(
		.WIDTH(AUX_W),
		.DEPTH(PALETTE_DEPTH)
	) u_aux (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (widx_s1),
		.wdata  ({hue_u_s1, wch_s1[4]}),
		.re     (mem_re),
		.raddr_a(lo_addr),
		.raddr_b(hi_addr),
		.rdata_a(aux_a),
		.rdata_b(aux_b)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			frac_s2 <= frac_s1;
		end
	end

	// stage 2: unpack both entries; in hsv or hsl borrow a missing hue, or zero both if both are missing
	assign ua = aux_a[CB];
	assign ub = aux_b[CB];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ca[i] = main_a[i*CB +: CB];
			cb[i] = main_b[i*CB +: CB];
		end
		ca[4] = aux_a[CB-1:0];
		cb[4] = aux_b[CB-1:0];
		if (hue_fix_en) begin
			priority if (ua && ub) begin
				ca[0] = '0;
				cb[0] = '0;
			end else if (ua) begin
				ca[0] = main_b[CB-1:0];
			end else if (ub) begin
				cb[0] = main_a[CB-1:0];
			end else begin
				// both hues defined, keep them as read
			end
		end
	end

	for (genvar g = 0; g < 5; g++) begin : g_lerp
		pci_lerp #(
			.CHANNEL_BITS(CB)
		) u_lerp (
			.clk (clk),
			.en  (en3),
			.a   (ca[g]),
			.b   (cb[g]),
			.frac(frac_s2),
			.res (res[g])
		);
	end

	// stage 3: empty palette gives black, alpha only lives in cmyk
	always_comb begin
		if (n_c == '0) begin
			fin[0] = '0;
			fin[1] = '0;
			fin[2] = '0;
			fin[3] = CHAN_MAX;
			fin[4] = is_cmyk ? CHAN_MAX : '0;
		end else begin
			for (int i = 0; i < 4; i++) begin
				fin[i] = res[i];
			end
			fin[4] = is_cmyk ? res[4] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			rsp.out_chan_0 <= CHAN_W'(fin[0]);
			rsp.out_chan_1 <= CHAN_W'(fin[1]);
			rsp.out_chan_2 <= CHAN_W'(fin[2]);
			rsp.out_chan_3 <= CHAN_W'(fin[3]);
			rsp.out_chan_4 <= CHAN_W'(fin[4]);
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/pci_ram.sv */
// generic memory, one write port and two registered read ports
`default_nettype none
module pci_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/pci_index.sv */
// position register and neighbour entry selection
`default_nettype none
module pci_index #(
	parameter int PALETTE_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [pci_pkg::VALUE_W-1:0]         value,
	input  wire logic [$clog2(PALETTE_DEPTH+1)-1:0]  nm1,
	output logic      [$clog2(PALETTE_DEPTH)-1:0]    lo_addr,
	output logic      [$clog2(PALETTE_DEPTH)-1:0]    hi_addr,
	output logic      [pci_pkg::FRAC_W-1:0]          frac
);
	import pci_pkg::*;

	localparam int CW = $clog2(PALETTE_DEPTH+1);
	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int PW = VALUE_W + CW;

	logic [VALUE_W-1:0] vsat;
	logic [PW-1:0]      pos_s1;
	logic [CW:0]        lo_full;
	logic [CW-1:0]      lo_c;
	logic [CW-1:0]      hi_c;

	// saturate to 1.0 and scale by the span of the palette
	assign vsat = (value > ONE_Q16) ? ONE_Q16 : value;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= PW'(vsat) * PW'(nm1);
		end
	end

	assign lo_full = pos_s1[PW-1:FRAC_W];

	always_comb begin
		if (lo_full >= {1'b0, nm1}) begin
			lo_c = nm1;
		end else begin
			lo_c = lo_full[CW-1:0];
		end
		if (lo_c == nm1) begin
			hi_c = nm1;
		end else begin
			hi_c = lo_c + CW'(1);
		end
	end

	assign lo_addr = AW'(lo_c);
	assign hi_addr = AW'(hi_c);
	assign frac    = pos_s1[FRAC_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/pci_lerp.sv */
// one channel blend: registered difference product, then rounding add
`default_nettype none
module pci_lerp #(
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [CHANNEL_BITS-1:0]     a,
	input  wire logic [CHANNEL_BITS-1:0]     b,
	input  wire logic [pci_pkg::FRAC_W-1:0]  frac,
	output logic      [CHANNEL_BITS-1:0]     res
);
	import pci_pkg::*;

	localparam int PW = CHANNEL_BITS + FRAC_W + 2;

	logic signed [CHANNEL_BITS:0]   diff;
	logic signed [FRAC_W:0]         frac_s;
	logic signed [PW-1:0]           prod_s3;
	logic        [CHANNEL_BITS-1:0] a_s3;
	logic signed [PW-1:0]           rnd;
	logic signed [PW-1:0]           sum;

	// a*(1-f) + b*f == a + (b-a)*f, the a term is exact
	assign diff   = $signed({1'b0, b}) - $signed({1'b0, a});
	assign frac_s = $signed({1'b0, frac});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= diff * frac_s;
			a_s3    <= a;
		end
	end

	assign rnd = prod_s3 + PW'(ROUND_HALF);
	assign sum = (rnd >>> FRAC_W) + $signed(PW'(a_s3));
	assign res = sum[CHANNEL_BITS-1:0];

endmodule
`default_nettype wire

/* bench/palette_colormap_interpolator_top_tb.sv */
// self-checking testbench of the palette colormap interpolator top level
`timescale 1ns / 1ps
module palette_colormap_interpolator_top_tb;
	import pci_pkg::*;

	// cycles to let a write settle in the pipeline before a register write
	localparam int SETTLE_CYCLES = 8;
	// cycles with no accepted word before the run is declared hung
	localparam int HANG_LIMIT    = 4000;
	localparam int PHASE_WORDS   = 38;
	localparam int PHASE_COUNT   = 10;
	localparam int MAX_REPORTS   = 10;

	typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

	// one row of the opening script: a register write or a word, the latter
	// optionally with its result typed in
	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_sel;
		logic [CFG_DATA_W-1:0]  reg_data;
		req_word_t              word;
		bit                     known;
		rsp_word_t              colour;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_ready;
	req_word_t             req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_word_t             rsp;

	// bench copy of the block's registers and palette
	logic [1:0]            cur_mode;
	logic [4:0]            cur_count;
	logic [CHAN_W-1:0]     pal_chan [16][5];
	bit                    pal_hue_undef [16];

	rsp_word_t             pending_colours [$];
	script_row_t           opening_script [$];
	int                    err_count;
	int                    quiet_cycles;
	bit                    calm;

	palette_colormap_interpolator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// rounded blend of two channels by a q0.16 fraction
	function automatic logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
			logic [FRAC_W-1:0] f);
		longint unsigned s;
		s = longint'(a) * (65536 - longint'(f)) + longint'(b) * longint'(f) + 32768;
		return s[31:16];
	endfunction

	// applies one word to the bench palette; returns 1 and the colour for a lookup
	function automatic bit palette_step(input req_word_t w, output rsp_word_t colour);
		logic [CHAN_W-1:0] lo_ch [5];
		logic [CHAN_W-1:0] hi_ch [5];
		logic [CHAN_W-1:0] mix [5];
		int unsigned       n;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       v;
		int unsigned       pos;
		bit                got;
		colour = '0;
		got = 1'b0;
		if (w.command == CMD_WRITE) begin
			pal_chan[w.entry_index] = '{w.chan_0, w.chan_1, w.chan_2, w.chan_3, w.chan_4};
			pal_hue_undef[w.entry_index] = w.hue_undefined;
		end else begin
			got = 1'b1;
			n = (cur_count > 16) ? 16 : cur_count;
			if (n == 0) begin
				// black in whatever space is configured
				mix = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
					(cur_mode == MODE_CMYK) ? 16'hFFFF : 16'h0000};
			end else if (n == 1) begin
				// single entry comes back as stored, undefined hue and all
				mix = pal_chan[0];
			end else begin
				v = (w.value > ONE_Q16) ? ONE_Q16 : w.value;
				pos = v * (n - 1);
				lo = pos >> 16;
				if (lo > n - 1)
					lo = n - 1;
				hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
				lo_ch = pal_chan[lo];
				hi_ch = pal_chan[hi];
				if (cur_mode == MODE_HSV || cur_mode == MODE_HSL) begin
					// an undefined hue borrows the neighbour's, or zero if both are
					if (pal_hue_undef[lo] && pal_hue_undef[hi]) begin
						lo_ch[0] = '0;
						hi_ch[0] = '0;
					end else if (pal_hue_undef[lo]) begin
						lo_ch[0] = hi_ch[0];
					end else if (pal_hue_undef[hi]) begin
						hi_ch[0] = lo_ch[0];
					end
				end
				for (int k = 0; k < 5; k++)
					mix[k] = mix_chan(lo_ch[k], hi_ch[k], pos[15:0]);
			end
			if (cur_mode != MODE_CMYK)
				mix[4] = '0;
			colour = '{mix[0], mix[1], mix[2], mix[3], mix[4]};
		end
		return got;
	endfunction

	// ---------------------------------------------------------------- script rows

	function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] sel,
			logic [CFG_DATA_W-1:0] data);
		script_row_t r;
		r = '{ROW_REG, sel, data, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic script_row_t word_row(logic cmd, logic [IDX_W-1:0] idx,
			logic [VALUE_W-1:0] value, logic hue, logic [5*CHAN_W-1:0] chans);
		script_row_t r;
		r = '{ROW_WORD, '0, '0, '0, 1'b0, '0};
		r.word.command = cmd;
		r.word.entry_index = idx;
		r.word.value = value;
		{r.word.hue_undefined, r.word.chan_0, r.word.chan_1, r.word.chan_2,
			r.word.chan_3, r.word.chan_4} = {hue, chans};
		return r;
	endfunction

	// lookup whose colour is plain from the spec
	function automatic script_row_t known_row(logic [VALUE_W-1:0] value,
			logic [5*CHAN_W-1:0] colour);
		script_row_t r;
		r = word_row(CMD_LOOKUP, '0, value, 1'b0, '0);
		r.known = 1'b1;
		r.colour = colour;
		return r;
	endfunction

	// ---------------------------------------------------------------- random helpers

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic req_word_t random_word();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(req_word_t)-1:0];
	endfunction

	// lookup position, leaning on the saturation edge and entry boundaries
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return VALUE_W'($urandom_range(0, 131071));
		else if (r < 7)
			return VALUE_W'($urandom_range(0, 65536));
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 17'h0FFFF;
			2: return ONE_Q16;
			3: return 17'h10001;
			4: return 17'h1FFFF;
			default: return VALUE_W'(65536 - $urandom_range(1, 64));
		endcase
	endfunction

	// ---------------------------------------------------------------- driving

	// present one word and hold it until it is taken
	task automatic send_word(input req_word_t w);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// send a word and queue the colour it should give
	task automatic run_word(input req_word_t w, input bit known, input rsp_word_t typed);
		rsp_word_t c;
		send_word(w);
		if (palette_step(w, c))
			pending_colours.push_back(known ? typed : c);
	endtask

	// wait for the pipe to empty, then write a register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
		req_valid <= 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
		// trailing palette writes give no result, so give them time to land
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_INTERP_MODE)
			cur_mode = data[1:0];
		else
			cur_count = data;
	endtask

	// one random phase: set both registers, then a mix of writes and lookups
	task automatic run_phase(input logic [1:0] mode, input logic [4:0] count);
		req_word_t w;
		write_reg(REG_INTERP_MODE, {3'b000, mode});
		write_reg(REG_ENTRY_COUNT, count);
		for (int i = 0; i < PHASE_WORDS; i++) begin
			w = random_word();
			if ($urandom_range(0, 4) == 0) begin
				w.command = CMD_WRITE;
			end else begin
				w.command = CMD_LOOKUP;
				w.value = pick_value();
			end
			run_word(w, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------- result side

	// result ready with random stalls, and runs of plain acceptance
	initial begin : rsp_side
		int hold;
		rsp_ready = 1'b0;
		forever begin
			hold = idle_len();
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic note_error(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// compare each accepted colour word with the oldest one waiting
	always @(posedge clk) begin
		rsp_word_t      want;
		logic [79:0]    want_bits;
		logic [79:0]    got_bits;
		if (arst_n && rsp_valid && rsp_ready) begin
			got_bits = rsp;
			if (pending_colours.size() == 0) begin
				note_error($sformatf("colour word with nothing expected: %h", got_bits));
			end else begin
				want = pending_colours.pop_front();
				want_bits = want;
				for (int k = 0; k < 5; k++)
					if (got_bits[79-16*k -: 16] !== want_bits[79-16*k -: 16])
						note_error($sformatf("out_chan_%0d expected %h, got %h", k,
							want_bits[79-16*k -: 16], got_bits[79-16*k -: 16]));
			end
		end
	end

	// hang guard: too long with no word moving on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin : stimulus
		logic [1:0] mode_plan [6];
		logic [4:0] count_plan [6];
		req_word_t  w;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		err_count = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		cur_mode = MODE_RGB;
		cur_count = '0;
		// extremes first: full palette, counts past the depth, one entry, none
		mode_plan = '{MODE_HSV, MODE_HSL, MODE_CMYK, MODE_RGB, MODE_HSL, MODE_CMYK};
		count_plan = '{5'd16, 5'd31, 5'd17, 5'd2, 5'd1, 5'd0};

		// opening script: black with no entries, single entry, hue borrowing,
		// position saturation, count changes across spaces
		opening_script = '{
			known_row(17'h00000, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000}),
			reg_row(REG_INTERP_MODE, 5'(MODE_CMYK)),
			known_row(17'h1FFFF, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}),
			word_row(CMD_WRITE, 4'd0, 17'h00000, 1'b1, {5{16'hFFFF}}),
			word_row(CMD_WRITE, 4'd1, 17'h00000, 1'b0, {5{16'h0000}}),
			word_row(CMD_WRITE, 4'd2, 17'h00000, 1'b1,
				{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F}),
			word_row(CMD_WRITE, 4'd15, 17'h1FFFF, 1'b0,
				{16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5}),
			reg_row(REG_ENTRY_COUNT, 5'd1),
			known_row(17'h1FFFF, {5{16'hFFFF}}),
			reg_row(REG_INTERP_MODE, 5'(MODE_HSV)),
			known_row(17'h00000, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}),
			reg_row(REG_ENTRY_COUNT, 5'd2),
			word_row(CMD_LOOKUP, 4'd0, 17'h00000, 1'b0, '0),
			word_row(CMD_LOOKUP, 4'd0, 17'h08000, 1'b0, '0),
			word_row(CMD_LOOKUP, 4'd0, 17'h0FFFF, 1'b0, '0),
			word_row(CMD_LOOKUP, 4'd0, 17'h10000, 1'b0, '0),
			word_row(CMD_LOOKUP, 4'd0, 17'h1FFFF, 1'b0, '0),
			reg_row(REG_ENTRY_COUNT, 5'd3),
			reg_row(REG_INTERP_MODE, 5'(MODE_HSL)),
			word_row(CMD_LOOKUP, 4'd0, 17'h08000, 1'b0, '0),
			word_row(CMD_LOOKUP, 4'd0, 17'h0C000, 1'b0, '0),
			word_row(CMD_WRITE, 4'd1, 17'h00000, 1'b1,
				{16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001}),
			word_row(CMD_LOOKUP, 4'd0, 17'h0C000, 1'b0, '0),
			word_row(CMD_LOOKUP, 4'd0, 17'h04000, 1'b0, '0),
			reg_row(REG_INTERP_MODE, 5'(MODE_RGB)),
			word_row(CMD_LOOKUP, 4'd0, 17'h0FFFF, 1'b0, '0),
			reg_row(REG_ENTRY_COUNT, 5'd0),
			known_row(17'h12345, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000})
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_script[i]) begin
			if (opening_script[i].kind == ROW_REG)
				write_reg(opening_script[i].reg_sel, opening_script[i].reg_data);
			else
				run_word(opening_script[i].word, opening_script[i].known,
					opening_script[i].colour);
		end

		// fill the whole palette so any count can be looked up safely
		for (int e = 0; e < 16; e++) begin
			w = random_word();
			w.command = CMD_WRITE;
			w.entry_index = IDX_W'(e);
			run_word(w, 1'b0, '0);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			// every third phase the sender never pauses
			calm = (p % 3 == 2);
			if (p < 6)
				run_phase(mode_plan[p], count_plan[p]);
			else
				run_phase(2'($urandom_range(0, 3)), 5'($urandom_range(2, 16)));
		end

		req_valid <= 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
